[rtl/mbtb_pkg.sv]
package mbtb_pkg;

    localparam int unsigned FIELD_COUNT = 6;

    localparam logic [3:0] POS_FIELD_FIRST = 4'd6;
    localparam logic [3:0] POS_FIELD_LAST  = 4'd11;
    localparam logic [3:0] POS_DONE        = 4'd12;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] HDR_MAGIC    = 8'd77;
    localparam logic [7:0] HDR_RESERVED = 8'd0;
    localparam logic [7:0] HDR_LEN      = 8'd9;
    localparam logic [7:0] HDR_CMD      = 8'd50;

    // Output frame slots
    localparam logic [3:0] SLOT_MAGIC       = 4'd0;
    localparam logic [3:0] SLOT_RESERVED    = 4'd1;
    localparam logic [3:0] SLOT_SEQ         = 4'd2;
    localparam logic [3:0] SLOT_LEN         = 4'd3;
    localparam logic [3:0] SLOT_CMD         = 4'd4;
    localparam logic [3:0] SLOT_FIELD_FIRST = 4'd5;
    localparam logic [3:0] SLOT_CRC_LO      = 4'd11;
    localparam logic [3:0] SLOT_CRC_HI      = 4'd12;

    typedef struct packed {
        logic [7:0]                  seq;
        logic [FIELD_COUNT-1:0][7:0] fields;
        logic [15:0]                 crc;
    } t_frame_desc;

    // CRC-16/Modbus, one byte, LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/mbtb_if.sv]
interface mbtb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_end;

    modport source (output valid, output in_byte, output frame_end, input ready);
    modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface mbtb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[rtl/mbtb_fifo.sv]
module mbtb_fifo
    import mbtb_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_wdata,
    input  logic        i_pop,
    output t_frame_desc o_rdata,
    output logic        o_full,
    output logic        o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_frame_desc r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

[rtl/mbtb_front.sv]
module mbtb_front
    import mbtb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbtb_in_if.sink     i_in,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_frame_desc o_q_wdata
);

    logic [3:0]                  r_pos, n_pos;
    logic [15:0]                 r_crc, n_crc;
    logic [7:0]                  r_seq, n_seq;
    logic [FIELD_COUNT-1:0][7:0] r_fields;
    logic                        w_accept;
    logic                        w_in_field;
    logic [2:0]                  w_field_idx;
    logic [15:0]                 w_crc_fold;

    // Stall only on the last field byte (byte 11) while the queue has no room
    assign i_in.ready  = !((r_pos == POS_FIELD_LAST) && i_q_full);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_in_field  = (r_pos >= POS_FIELD_FIRST) && (r_pos < POS_DONE);
    assign w_field_idx = 3'(r_pos - POS_FIELD_FIRST);
    assign w_crc_fold  = crc_fold(r_crc, i_in.in_byte);

    assign o_q_push = w_accept && (r_pos == POS_FIELD_LAST);

    always_comb begin
        o_q_wdata           = '0;
        o_q_wdata.seq       = r_seq;
        o_q_wdata.fields    = r_fields;
        o_q_wdata.fields[FIELD_COUNT-1] = i_in.in_byte;
        o_q_wdata.crc       = w_crc_fold;
    end

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        n_seq = r_seq;
        if (w_accept) begin
            if (r_pos < POS_DONE) begin
                n_pos = r_pos + 1'b1;
                if (w_in_field) begin
                    n_crc = w_crc_fold;
                end
                if (r_pos == POS_FIELD_LAST) begin
                    n_seq = r_seq + 1'b1;
                end
            end
            if (i_in.frame_end) begin
                n_pos = '0;
                n_crc = CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
            r_seq <= '0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_field) begin
            r_fields[w_field_idx] <= i_in.in_byte;
        end
    end

endmodule

[rtl/mbtb_back.sv]
module mbtb_back
    import mbtb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_desc i_q_rdata,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    mbtb_out_if.source  o_out
);

    logic [3:0] r_slot, n_slot;
    logic       w_accept;
    logic [3:0] w_field_slot;

    assign o_out.valid  = !i_q_empty;
    assign w_accept     = o_out.valid && o_out.ready;
    assign o_q_pop      = w_accept && (r_slot == SLOT_CRC_HI);
    assign o_out.out_last = (r_slot == SLOT_CRC_HI);
    assign w_field_slot = r_slot - SLOT_FIELD_FIRST;

    always_comb begin
        case (r_slot)
            SLOT_MAGIC:    o_out.out_byte = HDR_MAGIC;
            SLOT_RESERVED: o_out.out_byte = HDR_RESERVED;
            SLOT_SEQ:      o_out.out_byte = i_q_rdata.seq;
            SLOT_LEN:      o_out.out_byte = HDR_LEN;
            SLOT_CMD:      o_out.out_byte = HDR_CMD;
            SLOT_CRC_LO:   o_out.out_byte = i_q_rdata.crc[7:0];
            SLOT_CRC_HI:   o_out.out_byte = i_q_rdata.crc[15:8];
            default: begin
                if (w_field_slot < 4'(FIELD_COUNT)) begin
                    o_out.out_byte = i_q_rdata.fields[w_field_slot[2:0]];
                end else begin
                    o_out.out_byte = '0;
                end
            end
        endcase
    end

    always_comb begin
        n_slot = r_slot;
        if (w_accept) begin
            n_slot = (r_slot == SLOT_CRC_HI) ? '0 : r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

[rtl/modbus_tcp_to_ble_frame_unit.sv]
// Channel  Dir  Payload               Handshake
// i_in     in   in_byte[8], frame_end  valid/ready, item on valid && ready
// o_out    out  out_byte[8], out_last  valid/ready, item on valid && ready
//
// The front takes one request byte per cycle, folds bytes 6..11 into the
// CRC and, on byte 11, pushes one frame descriptor into a QUEUE_DEPTH-deep
// queue. The back drains a descriptor as 13 bytes, one per cycle.
// Input stalls only on byte 11 while the queue is full; all other bytes
// are taken every cycle. Output stalls hold the current byte. Reset is
// synchronous, active low, and clears position, CRC, sequence and queue.
module modbus_tcp_to_ble_frame_unit
    import mbtb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbtb_in_if.sink    i_in,
    mbtb_out_if.source o_out
);

    t_frame_desc w_q_wdata;
    t_frame_desc w_q_rdata;
    logic        w_q_push;
    logic        w_q_pop;
    logic        w_q_full;
    logic        w_q_empty;

    // Front: track byte position, hold fields, run the CRC
    mbtb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_wdata (w_q_wdata)
    );

    // Queue of finished frames between front and back
    mbtb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_wdata (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_rdata (w_q_rdata),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Back: serialize each frame, mark the CRC high byte as last
    mbtb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_rdata (w_q_rdata),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

endmodule

[bench/tb_modbus_tcp_to_ble_frame_unit.sv]
// Testbench for the Modbus TCP request to BLE frame unit.
//
// Request bytes go in on req_ch one item at a time. Each accepted byte is
// folded into a local model of the framer: byte position, the six held
// request fields (unit, function, address, count), a CRC-16/Modbus and the
// 8-bit frame sequence. When that model sees byte 11 of a request, it queues
// the 13 BLE bytes that must come out. Every item taken from ble_ch is
// checked against the oldest queued byte, out_byte and out_last separately.
//
// Stimulus runs in two parts:
//   - a short directed table: a frame whose fields are all ones and that ends
//     on byte 11, a one-byte frame that must be dropped, and a frame whose
//     fields are all zeros with one trailing byte that carries the frame end.
//     The sequence byte of the two emitted frames is typed into the table.
//   - random requests: mostly well formed with random content and 0..3
//     trailing bytes, some cut short, a few with a long tail.
//
// Inputs change on the falling edge and outputs are sampled on the rising
// edge. Both sides idle at random, with bursts where they do not. The
// receiver twice holds ready low for a long stretch, so that the frame queue
// fills and the block stalls its input on byte 11.
module tb_modbus_tcp_to_ble_frame_unit;
    import mbtb_pkg::*;

    localparam int          REQ_BYTES_TARGET = 430;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          DRAIN_CYCLES     = 32;
    localparam int unsigned CYCLE_LIMIT      = 300000;

    // One row of the directed table. When pin_seq is set, the row is byte 11 of a
    // frame and seq is the sequence byte that frame must carry.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       pin_seq;
        logic [7:0] seq;
    } t_req_row;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_ble_byte;

    localparam int N_DIRECTED = 26;
    localparam t_req_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Fields all ones, frame end on byte 11 itself: first frame, sequence 0
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b1, 1'b1, 8'd0},
        // Frame of a single byte: dropped, sequence stays
        '{8'h00, 1'b1, 1'b0, 8'h00},
        // Plain MBAP header, fields all zeros, one trailing byte: sequence 1
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h06, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'd1},
        '{8'hA5, 1'b1, 1'b0, 8'h00}
    };

    logic i_clk;
    logic i_rst_n;

    mbtb_in_if  req_ch ();
    mbtb_out_if ble_ch ();

    modbus_tcp_to_ble_frame_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (ble_ch)
    );

    // Local copy of the framer state
    logic [3:0]  req_pos;
    logic [7:0]  req_fields [FIELD_COUNT];
    logic [15:0] req_crc;
    logic [7:0]  ble_seq;

    t_ble_byte   frame_bytes_due [$];
    int          frame_bytes_seen;
    int          mismatches;
    int unsigned cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Fold one byte into the CRC-16/Modbus, LSB first
    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] c;
        logic        carry;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            carry = c[0];
            c     = {1'b0, c[15:1]};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void queue_ble_byte(input logic [7:0] b, input logic last);
        t_ble_byte e;
        e.data = b;
        e.last = last;
        frame_bytes_due.push_back(e);
    endfunction

    // Advance the local framer by one accepted request byte. A pinned sequence
    // replaces the predicted one in the queued frame.
    function automatic void absorb_request_byte(input logic [7:0] b, input logic fin,
                                                input logic pin_seq, input logic [7:0] seq);
        if (req_pos < POS_DONE) begin
            if (req_pos >= POS_FIELD_FIRST) begin
                req_fields[3'(req_pos - POS_FIELD_FIRST)] = b;
                req_crc = modbus_crc_next(req_crc, b);
            end
            if (req_pos == POS_FIELD_LAST) begin
                queue_ble_byte(HDR_MAGIC, 1'b0);
                queue_ble_byte(HDR_RESERVED, 1'b0);
                queue_ble_byte(pin_seq ? seq : ble_seq, 1'b0);
                queue_ble_byte(HDR_LEN, 1'b0);
                queue_ble_byte(HDR_CMD, 1'b0);
                for (int i = 0; i < FIELD_COUNT; i++) begin
                    queue_ble_byte(req_fields[i], 1'b0);
                end
                queue_ble_byte(req_crc[7:0], 1'b0);
                queue_ble_byte(req_crc[15:8], 1'b1);
                ble_seq = ble_seq + 8'd1;
            end
            req_pos = req_pos + 4'd1;
        end
        if (fin) begin
            req_pos = '0;
            req_crc = CRC_INIT;
        end
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 19) < 15) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    // Offer one request byte; entered and left at a falling edge. Valid stays
    // high from one item to the next unless a gap is taken.
    task automatic offer_request_byte(input logic [7:0] b, input logic fin,
                                      input logic pin_seq, input logic [7:0] seq,
                                      input bit burst);
        int gap;
        gap = 0;
        if (!burst && $urandom_range(0, 9) >= 6) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.in_byte   <= b;
        req_ch.frame_end <= fin;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        absorb_request_byte(b, fin, pin_seq, seq);
        @(negedge i_clk);
    endtask

    // Send one random request and return how many bytes it offered.
    task automatic send_random_request(output int sent);
        int  kind;
        int  len;
        bit  burst;
        kind  = $urandom_range(0, 9);
        burst = ($urandom_range(0, 3) == 0);
        if (kind < 7) begin
            len = 12 + $urandom_range(0, 3);
        end else if (kind < 9) begin
            len = $urandom_range(1, 11);
        end else begin
            len = 12 + $urandom_range(4, 20);
        end
        for (int i = 0; i < len; i++) begin
            offer_request_byte(8'($urandom_range(0, 255)), i == len - 1, 1'b0, 8'h00,
                               burst);
        end
        sent = len;
    endtask

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls in choppy stretches, clean stretches, and two
    // long hold-offs to back the block up into its input.
    initial begin
        int        stall_left;
        int        hold_left;
        int        seg_left;
        int        next_hold;
        bit        choppy;
        t_ble_byte want;
        stall_left       = 0;
        hold_left        = 0;
        seg_left         = 0;
        next_hold        = 100;
        choppy           = 1'b0;
        frame_bytes_seen = 0;
        mismatches       = 0;
        ble_ch.ready     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 64);
                choppy   = ($urandom_range(0, 2) != 0);
            end
            seg_left--;
            if (next_hold > 0 && frame_bytes_seen >= next_hold) begin
                hold_left = HOLD_OFF_CYCLES;
                next_hold = (next_hold == 100) ? 260 : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                ble_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ble_ch.ready <= 1'b0;
            end else begin
                ble_ch.ready <= 1'b1;
                if (choppy && $urandom_range(0, 3) == 0) begin
                    stall_left = idle_len();
                end
            end
            @(posedge i_clk);
            if (i_rst_n && ble_ch.valid && ble_ch.ready) begin
                frame_bytes_seen++;
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected item out_byte %0d out_last %0b",
                             $time, ble_ch.out_byte, ble_ch.out_last);
                    mismatches++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (ble_ch.out_byte !== want.data) begin
                        $display("%0t: out_byte expected %0d actual %0d",
                                 $time, want.data, ble_ch.out_byte);
                        mismatches++;
                    end
                    if (ble_ch.out_last !== want.last) begin
                        $display("%0t: out_last expected %0b actual %0b",
                                 $time, want.last, ble_ch.out_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Sender and end of run
    initial begin
        int sent;
        int req_bytes;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.in_byte   = '0;
        req_ch.frame_end = 1'b0;
        req_pos          = '0;
        req_crc          = CRC_INIT;
        ble_seq          = '0;
        foreach (req_fields[i]) begin
            req_fields[i] = '0;
        end

        // Hold reset from the start, release on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            offer_request_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].fin,
                               DIRECTED_ROWS[r].pin_seq, DIRECTED_ROWS[r].seq,
                               r < 12);
        end

        req_bytes = N_DIRECTED;
        while (req_bytes < REQ_BYTES_TARGET) begin
            send_random_request(sent);
            req_bytes += sent;
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding frame bytes, then let the block settle
        while (frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
